// File: hdl/rv32i_subset_execute_assert.svh
// Assertion macros used by the execute block top level.
`ifndef RV32I_SUBSET_EXECUTE_ASSERT_SVH
`define RV32I_SUBSET_EXECUTE_ASSERT_SVH
`ifndef SYNTHESIS
`define RVX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define RVX_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define RVX_ASSERT(lbl, prop, msg)
`define RVX_NEVER(lbl, cond, msg)
`endif
`endif

// File: hdl/rvx_pkg.sv
// Types and constants for the RV32I subset execute block.
package rvx_pkg;

	localparam int REG_COUNT = 32;

	localparam logic [6:0] OP_RALU   = 7'h33;
	localparam logic [6:0] OP_IALU   = 7'h13;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_JAL    = 7'h6F;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MEM     = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	typedef struct packed {
		logic [31:0] npc;
		logic        wr;
		logic [4:0]  rd;
		logic [31:0] val;
		logic [1:0]  st;
		logic        load;
		logic        store;
		logic [31:0] off;
		logic [2:0]  f3;
	} exec_t;

endpackage

// File: hdl/rv32i_subset_execute.sv
// Top level of the RV32I subset execute block.
// Usage:
//   Input channel: instruction with in_valid / in_stall; a word transfers when
//   in_valid is high and in_stall low. Result channel: next_pc, reg_write,
//   reg_index, reg_value and status with out_valid / out_stall, one result per
//   instruction. Configuration: cfg_data with cfg_valid / cfg_ready writes
//   data_base (the data window start); cfg_ready is always high.
//   A result goes from the execute register to the output registers, a load
//   that reaches memory through the load phase. Throughput: one instruction per
//   cycle while out_stall is low; a load holds in_stall high in its execute
//   phase, since its data comes from the registered read of the data RAM.
//   Register operands come from two registered-read copies of the register
//   file, read at transfer, with forwarding of the write in the same cycle.
//   Reset: pc, register file and data_base are reset at once; the data memory
//   is cleared one 4-byte row per cycle, with in_stall held high meanwhile.
//   When out_stall holds a result, the instruction behind it waits in the
//   execute register and in_stall rises.
module rv32i_subset_execute #(
	parameter int DATA_BYTES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instruction,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] next_pc,
	output logic        reg_write,
	output logic [4:0]  reg_index,
	output logic [31:0] reg_value,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import rvx_pkg::*;
	`include "rv32i_subset_execute_assert.svh"

	localparam int ROWS = (DATA_BYTES + 3) / 4;
	localparam int ROWW = $clog2(ROWS);
	localparam int RFW  = $clog2(REG_COUNT);

	logic [31:0] base_q, pc_q;
	logic [REG_COUNT-1:0] rf_vld_q;
	logic        clr_q;
	logic [ROWW-1:0] clr_cnt_q;

	logic        busy_s1, ld_s2;
	logic [31:0] ins_s1;
	logic        v1_s1, v2_s1, byp1_s1, byp2_s1;
	logic [31:0] bv1_s1, bv2_s1;
	logic [2:0]  f3_s2;
	logic [1:0]  lo_s2;
	logic [4:0]  rd_s2;

	logic        accept, out_can, fire;
	logic [31:0] a, b, ram1_q, ram2_q;
	exec_t       ex;

	logic        rf_we;
	logic [4:0]  rf_waddr;
	logic [31:0] rf_wdata;

	logic [31:0] res_npc, res_val, ld_val;
	logic        res_wr;
	logic [4:0]  res_rd;
	logic [1:0]  res_st;

	logic [ROWW-1:0] lane_addr [4];
	logic            lane_we [4];
	logic [7:0]      lane_wd [4];
	logic [7:0]      lane_rd [4];
	logic [7:0]      bt [4];
	logic            mem_re;
	logic [2:0]      st_n;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign out_can   = !out_valid || !out_stall;
	assign fire      = ((busy_s1 && !ex.load) || ld_s2) && out_can;
	assign in_stall  = clr_q || (busy_s1 && ex.load) || ((busy_s1 || ld_s2) && !out_can);

	assign a = byp1_s1 ? bv1_s1 : (v1_s1 ? ram1_q : 32'd0);
	assign b = byp2_s1 ? bv2_s1 : (v2_s1 ? ram2_q : 32'd0);

	rvx_exec #(.DATA_BYTES(DATA_BYTES)) u_exec (
		.ins (ins_s1),
		.a   (a),
		.b   (b),
		.pc  (pc_q),
		.base(base_q),
		.ex  (ex)
	);

	// register file: one copy per read port, same write
	rvx_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf1 (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(accept), .raddr(instruction[19:15]), .rdata(ram1_q)
	);
	rvx_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf2 (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(accept), .raddr(instruction[24:20]), .rdata(ram2_q)
	);

	// load data, big-endian: byte i of the access sits in lane (off + i) mod 4
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			bt[i] = lane_rd[2'(lo_s2 + 2'(i))];
		end
		case (f3_s2[1:0])
			2'd0: ld_val = f3_s2[2] ? {24'd0, bt[0]} : {{24{bt[0][7]}}, bt[0]};
			2'd1: ld_val = f3_s2[2] ? {16'd0, bt[0], bt[1]}
				: {{16{bt[0][7]}}, bt[0], bt[1]};
			default: ld_val = {bt[0], bt[1], bt[2], bt[3]};
		endcase
	end

	always_comb begin
		if (ld_s2) begin
			res_npc = pc_q + 32'd4;
			res_wr  = rd_s2 != 5'd0;
			res_rd  = res_wr ? rd_s2 : 5'd0;
			res_val = res_wr ? ld_val : 32'd0;
			res_st  = ST_OK;
		end else begin
			res_npc = ex.npc;
			res_wr  = ex.wr;
			res_rd  = ex.rd;
			res_val = ex.val;
			res_st  = ex.st;
		end
	end

	assign rf_we    = fire && res_wr;
	assign rf_waddr = res_rd;
	assign rf_wdata = res_val;

	// data memory lanes
	assign mem_re = busy_s1 && ex.load;
	assign st_n   = (ex.f3 == 3'd0) ? 3'd1 : (ex.f3 == 3'd1) ? 3'd2 : 3'd4;

	always_comb begin
		logic [ROWW-1:0] row0;
		logic [1:0]      idx;
		logic [1:0]      sft;
		row0 = ex.off[ROWW+1:2];
		for (int l = 0; l < 4; l++) begin
			idx = 2'(l) - ex.off[1:0];
			sft = 2'(st_n - 3'd1 - {1'b0, idx});
			if (clr_q) begin
				lane_addr[l] = clr_cnt_q;
				lane_we[l]   = 1'b1;
				lane_wd[l]   = 8'd0;
			end else begin
				lane_addr[l] = (2'(l) >= ex.off[1:0]) ? row0 : row0 + 1'b1;
				lane_we[l]   = fire && busy_s1 && ex.store && ({1'b0, idx} < st_n);
				lane_wd[l]   = 8'(b >> {sft, 3'b000});
			end
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		rvx_ram #(.WIDTH(8), .DEPTH(ROWS)) u_dm (
			.clk(clk), .we(lane_we[l]), .waddr(lane_addr[l]), .wdata(lane_wd[l]),
			.re(mem_re), .raddr(lane_addr[l]), .rdata(lane_rd[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= 32'd1024;
			pc_q      <= '0;
			rf_vld_q  <= '0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			busy_s1   <= 1'b0;
			ld_s2     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				base_q <= cfg_data;
			end
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == ROWW'(ROWS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (rf_we) begin
				rf_vld_q[rf_waddr[RFW-1:0]] <= 1'b1;
			end
			if (fire) begin
				pc_q <= res_npc;
			end
			// advance: stage 1 drains on fire or moves to the load phase
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (fire || (busy_s1 && ex.load)) begin
				busy_s1 <= 1'b0;
			end
			if (busy_s1 && ex.load) begin
				ld_s2 <= 1'b1;
			end else if (fire) begin
				ld_s2 <= 1'b0;
			end
			if (fire) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ins_s1  <= instruction;
			v1_s1   <= rf_vld_q[instruction[19:15]];
			v2_s1   <= rf_vld_q[instruction[24:20]];
			byp1_s1 <= rf_we && (rf_waddr == instruction[19:15]);
			byp2_s1 <= rf_we && (rf_waddr == instruction[24:20]);
			bv1_s1  <= rf_wdata;
			bv2_s1  <= rf_wdata;
		end
		if (busy_s1 && ex.load) begin
			f3_s2 <= ex.f3;
			lo_s2 <= ex.off[1:0];
			rd_s2 <= ins_s1[11:7];
		end
		if (fire) begin
			next_pc   <= res_npc;
			reg_write <= res_wr;
			reg_index <= res_rd;
			reg_value <= res_val;
			status    <= res_st;
		end
	end

	`RVX_NEVER(a_stage_excl, busy_s1 && ld_s2, "execute and load phase both active")
	`RVX_NEVER(a_no_x0_write, rf_we && rf_waddr == 5'd0, "write to register x0")
	`RVX_ASSERT(a_load_phase, (busy_s1 && ex.load) |=> ld_s2, "load did not enter load phase")
	`RVX_NEVER(a_no_mem_clear_busy, clr_q && (busy_s1 || ld_s2), "instruction during clear")
endmodule

// File: hdl/rvx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rvx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: hdl/rvx_exec.sv
// Decode and single-pass execute of one instruction.
module rvx_exec #(
	parameter int DATA_BYTES = 1024
) (
	input  logic [31:0]    ins,
	input  logic [31:0]    a,
	input  logic [31:0]    b,
	input  logic [31:0]    pc,
	input  logic [31:0]    base,
	output rvx_pkg::exec_t ex
);
	import rvx_pkg::*;

	logic [6:0]  op;
	logic [6:0]  f7;
	logic [2:0]  f3;
	logic [4:0]  rd;
	logic [31:0] imm_i, imm_s, imm_b, imm_j, pc4, addr, off;
	logic [4:0]  sh;
	logic [2:0]  n;
	logic        legal, slt, sltu, slti, sltiu, take;

	assign op    = ins[6:0];
	assign rd    = ins[11:7];
	assign f3    = ins[14:12];
	assign f7    = ins[31:25];
	assign imm_i = {{20{ins[31]}}, ins[31:20]};
	assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
	assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
	assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
	assign pc4   = pc + 32'd4;
	assign sh    = b[4:0];
	assign slt   = $signed(a) < $signed(b);
	assign sltu  = a < b;
	assign slti  = $signed(a) < $signed(imm_i);
	assign sltiu = a < imm_i;
	assign addr  = a + ((op == OP_STORE) ? imm_s : imm_i);
	assign off   = addr - base;

	always_comb begin
		if (op == OP_STORE) begin
			n = (f3 == 3'd0) ? 3'd1 : (f3 == 3'd1) ? 3'd2 : 3'd4;
		end else begin
			n = (f3[1:0] == 2'd0) ? 3'd1 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4;
		end
	end

	assign legal = ({1'b0, off} + 33'(n)) <= 33'(DATA_BYTES);

	always_comb begin
		ex       = '0;
		ex.npc   = pc4;
		ex.rd    = rd;
		ex.off   = off;
		ex.f3    = f3;
		ex.st    = ST_OK;
		take     = 1'b0;
		case (op)
			OP_RALU: begin
				ex.wr = 1'b1;
				if (f7 == F7_BASE) begin
					case (f3)
						3'd0: ex.val = a + b;
						3'd1: ex.val = a << sh;
						3'd2: ex.val = {31'd0, slt};
						3'd3: ex.val = {31'd0, sltu};
						3'd4: ex.val = a ^ b;
						3'd5: ex.val = a >> sh;
						3'd6: ex.val = a | b;
						default: ex.val = a & b;
					endcase
				end else if (f7 == F7_ALT && f3 == 3'd0) begin
					ex.val = a - b;
				end else if (f7 == F7_ALT && f3 == 3'd5) begin
					ex.val = 32'($signed(a) >>> sh);
				end else begin
					ex.st = ST_UNKNOWN;
				end
			end
			OP_IALU: begin
				ex.wr = 1'b1;
				case (f3)
					3'd0: ex.val = a + imm_i;
					3'd2: ex.val = {31'd0, slti};
					3'd3: ex.val = {31'd0, sltiu};
					3'd4: ex.val = a ^ imm_i;
					3'd6: ex.val = a | imm_i;
					3'd7: ex.val = a & imm_i;
					default: ex.st = ST_UNKNOWN;
				endcase
			end
			OP_LOAD: begin
				if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
					ex.st = ST_UNKNOWN;
				end else if (!legal) begin
					ex.st = ST_MEM;
				end else begin
					ex.load = 1'b1;
				end
			end
			OP_JALR: begin
				if (f3 != 3'd0) begin
					ex.st = ST_UNKNOWN;
				end else begin
					ex.npc = (a + imm_i) & ~32'd1;
					ex.val = pc4;
					ex.wr  = 1'b1;
				end
			end
			OP_STORE: begin
				if (f3 > 3'd2) begin
					ex.st = ST_UNKNOWN;
				end else if (!legal) begin
					ex.st = ST_MEM;
				end else begin
					ex.store = 1'b1;
				end
			end
			OP_BRANCH: begin
				case (f3)
					3'd0: take = a == b;
					3'd1: take = a != b;
					3'd4: take = slt;
					3'd5: take = !slt;
					3'd6: take = sltu;
					3'd7: take = !sltu;
					default: ex.st = ST_UNKNOWN;
				endcase
				if (take) begin
					ex.npc = pc + imm_b;
				end
			end
			OP_LUI: begin
				ex.val = {ins[31:12], 12'd0};
				ex.wr  = 1'b1;
			end
			OP_JAL: begin
				ex.val = pc4;
				ex.npc = pc + imm_j;
				ex.wr  = 1'b1;
			end
			default: ex.st = ST_UNKNOWN;
		endcase
		if (ex.st != ST_OK) begin
			ex.wr  = 1'b0;
			ex.npc = pc4;
		end
		if (rd == 5'd0) begin
			ex.wr = 1'b0;
		end
		if (!ex.wr) begin
			ex.val = '0;
			ex.rd  = '0;
		end
	end
endmodule
